// ===== hdl/rwpb_pkg.sv =====
// Shared widths, constants and types of the radial weight pixel blend.
package rwpb_pkg;

  localparam int RADIUS_W       = 10;
  localparam int MAXR_W         = 12;
  localparam int COORD_W        = 11;
  localparam int DELTA_W        = COORD_W + 1;
  localparam int SQR_W          = 2 * COORD_W;
  localparam int CHAN_W         = 8;
  localparam int MAX_RADIUS_DEF = 1023;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd50;

  localparam int SQ_RES_W  = 12;
  localparam int SQ_VAL_W  = 2 * SQ_RES_W;
  localparam int SQ_REM_W  = SQ_RES_W + 3;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = SQ_RES_W / SQ_STEPS;

  localparam int BL_STAGES = 3;

  typedef struct packed {
    logic [CHAN_W-1:0] base_blue;
    logic [CHAN_W-1:0] base_green;
    logic [CHAN_W-1:0] base_red;
    logic [CHAN_W-1:0] over_blue;
    logic [CHAN_W-1:0] over_green;
    logic [CHAN_W-1:0] over_red;
  } pix_t;

endpackage

// ===== hdl/rwpb_isqrt.sv =====
// Pipelined floor integer square root, two result bits per stage.
module rwpb_isqrt import rwpb_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_VAL_W-1:0] in_val,
  output logic [SQ_RES_W-1:0] out_root
);

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_RES_W-1:0] root;
    logic [SQ_VAL_W-1:0] val;
  } sq_state_t;

  function automatic sq_state_t sq_step(sq_state_t s);
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    sq_state_t           n;
    cur   = {s.rem[SQ_REM_W-3:0], s.val[SQ_VAL_W-1 -: 2]};
    trial = SQ_REM_W'({s.root, 2'b01});
    n.val = s.val << 2;
    if (cur >= trial) begin
      n.rem  = cur - trial;
      n.root = {s.root[SQ_RES_W-2:0], 1'b1};
    end else begin
      n.rem  = cur;
      n.root = {s.root[SQ_RES_W-2:0], 1'b0};
    end
    return n;
  endfunction

  sq_state_t st_r   [SQ_STAGES];
  sq_state_t st_nxt [SQ_STAGES];

  always_comb begin
    sq_state_t t;
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (s == 0) begin
        t.rem  = '0;
        t.root = '0;
        t.val  = in_val;
      end else begin
        t = st_r[s-1];
      end
      for (int k = 0; k < SQ_STEPS; k++) begin
        t = sq_step(t);
      end
      st_nxt[s] = t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_root = st_r[SQ_STAGES-1].root;

endmodule

// ===== hdl/rwpb_blend.sv =====
// Pipelined weighted blend of one colour channel with saturation.
module rwpb_blend import rwpb_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic                in_inside,
  input  logic [RADIUS_W-1:0] in_w,
  input  logic [CHAN_W-1:0]   in_base,
  input  logic [CHAN_W-1:0]   in_over,
  output logic [CHAN_W-1:0]   out_chan
);

  localparam int SUM_W  = 20;
  localparam int X_W    = 15;
  localparam int RCP_W  = 13;
  localparam int PROD_W = X_W + RCP_W;
  localparam int SHIFT  = 19;

  localparam logic [RCP_W-1:0] RECIP_100 = 13'd5243;
  localparam logic [SUM_W-1:0] SAT_LIMIT = 20'd25600;
  localparam logic [6:0]       HUNDRED   = 7'd100;

  logic signed [CHAN_W:0]   diff;
  logic signed [RADIUS_W:0] w_s;
  logic signed [SUM_W-1:0]  wd;
  logic        [X_W-1:0]    base100;
  logic signed [SUM_W-1:0]  sum_nxt;

  logic signed [SUM_W-1:0]  s1_sum_r;
  logic [CHAN_W-1:0]        s1_base_r, s2_base_r, s3_base_r;
  logic                     s1_ins_r, s2_ins_r, s3_ins_r;
  logic                     s2_neg_r, s3_neg_r;
  logic                     s2_sat_r, s3_sat_r;
  logic [X_W-1:0]           s2_x_r;
  logic [PROD_W-1:0]        s3_prod_r;

  assign diff    = $signed({1'b0, in_over}) - $signed({1'b0, in_base});
  assign w_s     = $signed({1'b0, in_w});
  assign wd      = w_s * diff;
  assign base100 = in_base * HUNDRED;
  assign sum_nxt = wd + $signed({{(SUM_W-X_W){1'b0}}, base100});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum_r  <= sum_nxt;
      s1_base_r <= in_base;
      s1_ins_r  <= in_inside;

      s2_neg_r  <= s1_sum_r[SUM_W-1];
      s2_sat_r  <= !s1_sum_r[SUM_W-1] && ($unsigned(s1_sum_r) >= SAT_LIMIT);
      s2_x_r    <= s1_sum_r[X_W-1:0];
      s2_base_r <= s1_base_r;
      s2_ins_r  <= s1_ins_r;

      s3_prod_r <= s2_x_r * RECIP_100;
      s3_neg_r  <= s2_neg_r;
      s3_sat_r  <= s2_sat_r;
      s3_base_r <= s2_base_r;
      s3_ins_r  <= s2_ins_r;
    end
  end

  always_comb begin
    if (!s3_ins_r) begin
      out_chan = s3_base_r;
    end else if (s3_neg_r) begin
      out_chan = '0;
    end else if (s3_sat_r) begin
      out_chan = '1;
    end else begin
      out_chan = s3_prod_r[SHIFT+CHAN_W-1:SHIFT];
    end
  end

endmodule

// ===== hdl/radial_weight_pixel_blend.sv =====
// Top level of the radial weight pixel blend.
//
// Input channel: in_valid / in_stall carry one pixel transaction: offsets
// within the square and a base and an overlay RGB pixel. Output channel:
// out_valid / out_stall carry one result transaction per input: the
// blended or passed RGB pixel and out_inside_res.
// Configuration: cfg_valid / cfg_ready write the radius; cfg_ready is
// always high. Write only while no transaction is in flight.
// The pipeline has 14 register stages; throughput is one pixel per cycle
// while out_stall does not hold the pipeline. Depth is set by the delta
// stage, the squaring and sum stages, the six-stage square root pipeline
// (two root bits per stage), the inside and weight stage, the three-stage
// blend with its divide-by-100 reciprocal multiply and the output register.
// Reset clears all valid bits and loads the radius with 50.
// While out_valid is high and out_stall is high, every stage holds and
// in_stall is raised; no transaction is lost or repeated.
module radial_weight_pixel_blend import rwpb_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RADIUS_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  in_offset_x,
  input  logic [COORD_W-1:0]  in_offset_y,
  input  logic [CHAN_W-1:0]   in_base_blue,
  input  logic [CHAN_W-1:0]   in_base_green,
  input  logic [CHAN_W-1:0]   in_base_red,
  input  logic [CHAN_W-1:0]   in_over_blue,
  input  logic [CHAN_W-1:0]   in_over_green,
  input  logic [CHAN_W-1:0]   in_over_red,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAN_W-1:0]   out_blue,
  output logic [CHAN_W-1:0]   out_green,
  output logic [CHAN_W-1:0]   out_red,
  output logic                out_inside_res
);

  localparam int DEPTH = 3 + SQ_STAGES + 1 + BL_STAGES + 1;
  localparam logic [MAXR_W-1:0] MAX_R = MAXR_W'(MAX_RADIUS);

  logic [RADIUS_W-1:0] radius_r;
  logic [RADIUS_W-1:0] r_sat;
  logic [RADIUS_W-1:0] r_half;
  logic                adv;
  logic [DEPTH-1:0]    vld_r;

  pix_t                     in_pix;
  logic signed [DELTA_W-1:0] ddx_nxt, ddy_nxt;
  logic signed [DELTA_W-1:0] a_ddx_r, a_ddy_r;
  pix_t                     a_pix_r, b_pix_r, c_pix_r, d_pix_r;
  logic signed [2*DELTA_W-1:0] sqx_nxt, sqy_nxt;
  logic [SQR_W-1:0]         b_sqx_r, b_sqy_r;
  logic [SQR_W:0]           c_dist_r;
  pix_t                     side_r [SQ_STAGES];
  logic [SQ_RES_W-1:0]      root;
  logic                     d_inside_r;
  logic [RADIUS_W-1:0]      d_w_r;
  logic [BL_STAGES-1:0]     ins_r;
  logic [CHAN_W-1:0]        bl_blue, bl_green, bl_red;
  logic [CHAN_W-1:0]        out_blue_r, out_green_r, out_red_r;
  logic                     out_inside_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_data;
    end
  end

  assign r_sat  = ({{(MAXR_W-RADIUS_W){1'b0}}, radius_r} > MAX_R) ?
                  MAX_R[RADIUS_W-1:0] : radius_r;
  assign r_half = r_sat >> 1;

  assign adv      = !vld_r[DEPTH-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  assign in_pix.base_blue  = in_base_blue;
  assign in_pix.base_green = in_base_green;
  assign in_pix.base_red   = in_base_red;
  assign in_pix.over_blue  = in_over_blue;
  assign in_pix.over_green = in_over_green;
  assign in_pix.over_red   = in_over_red;

  assign ddx_nxt = $signed({{(DELTA_W-RADIUS_W){1'b0}}, r_sat})
                 - $signed({1'b0, in_offset_x});
  assign ddy_nxt = $signed({{(DELTA_W-RADIUS_W){1'b0}}, r_half})
                 - $signed({1'b0, in_offset_y});
  assign sqx_nxt = a_ddx_r * a_ddx_r;
  assign sqy_nxt = a_ddy_r * a_ddy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ddx_r   <= ddx_nxt;
      a_ddy_r   <= ddy_nxt;
      a_pix_r   <= in_pix;
      b_sqx_r   <= sqx_nxt[SQR_W-1:0];
      b_sqy_r   <= sqy_nxt[SQR_W-1:0];
      b_pix_r   <= a_pix_r;
      c_dist_r  <= {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
      c_pix_r   <= b_pix_r;
      side_r[0] <= c_pix_r;
      for (int s = 1; s < SQ_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  rwpb_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .in_val   (SQ_VAL_W'(c_dist_r)),
    .out_root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      d_inside_r <= root < {{(SQ_RES_W-RADIUS_W){1'b0}}, r_sat};
      d_w_r      <= r_sat - root[RADIUS_W-1:0];
      d_pix_r    <= side_r[SQ_STAGES-1];
      ins_r      <= {ins_r[BL_STAGES-2:0], d_inside_r};
    end
  end

  rwpb_blend u_blend_blue (
    .clk       (clk),
    .en        (adv),
    .in_inside (d_inside_r),
    .in_w      (d_w_r),
    .in_base   (d_pix_r.base_blue),
    .in_over   (d_pix_r.over_blue),
    .out_chan  (bl_blue)
  );

  rwpb_blend u_blend_green (
    .clk       (clk),
    .en        (adv),
    .in_inside (d_inside_r),
    .in_w      (d_w_r),
    .in_base   (d_pix_r.base_green),
    .in_over   (d_pix_r.over_green),
    .out_chan  (bl_green)
  );

  rwpb_blend u_blend_red (
    .clk       (clk),
    .en        (adv),
    .in_inside (d_inside_r),
    .in_w      (d_w_r),
    .in_base   (d_pix_r.base_red),
    .in_over   (d_pix_r.over_red),
    .out_chan  (bl_red)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      out_blue_r   <= bl_blue;
      out_green_r  <= bl_green;
      out_red_r    <= bl_red;
      out_inside_r <= ins_r[BL_STAGES-1];
    end
  end

  assign out_valid      = vld_r[DEPTH-1];
  assign out_blue       = out_blue_r;
  assign out_green      = out_green_r;
  assign out_red        = out_red_r;
  assign out_inside_res = out_inside_r;

endmodule
